### sv/tsa_pkg.sv
// tsa_pkg: shared types and codes for the thread slot allocator
// holds command, status and sequencer state encodings; no dependencies
package tsa_pkg;

  localparam int ID_W = 32;
  localparam logic [ID_W-1:0] PENDING_MARK = '1;
  localparam logic [ID_W-1:0] EMPTY_MARK   = '0;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_LOOKUP  = 2'd2,
    CMD_RECLAIM = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_NO_FREE   = 3'd1,
    STS_FULL      = 3'd2,
    STS_MISMATCH  = 3'd3,
    STS_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SEQ_CLEAR,
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_FIN
  } seq_state_t;

endpackage

### sv/tsa_ram.sv
// tsa_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module tsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/thread_slot_allocator_core.sv
// thread_slot_allocator_core: maps thread ids to dense slot numbers
// depends on tsa_pkg and tsa_ram
//
//  channel | direction | ports                                    | handshake
//  in      | input     | in_command, in_thread_id, in_slot        | in_valid / in_ready
//  out     | output    | out_status, out_slot_out                 | out_valid / out_ready
//
// after reset the slot table is swept to zero, one slot a cycle, with in_ready low.
// allocate and lookup scan the table through the single read port and one shared
// comparator, one slot a cycle, each read word checked from the registered read port;
// free and reclaim check one slot; an allocate with no free count goes straight to
// the result.
// a finished word waits in the output register while the next command is taken;
// a result that finds that register still full holds the sequencer until it drains.
module thread_slot_allocator_core #(
  parameter int SLOTS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_command,
  input  logic [tsa_pkg::ID_W-1:0]         in_thread_id,
  input  logic [$clog2(SLOTS)-1:0]         in_slot,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       out_status,
  output logic [$clog2(SLOTS+1)-1:0]       out_slot_out
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int OUT_W  = $clog2(SLOTS + 1);
  localparam int FC_W   = $clog2(SLOTS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
  localparam logic [SLOT_W:0]   SLOTS_X   = (SLOT_W + 1)'(SLOTS);
  localparam logic [OUT_W-1:0]  SLOT_NONE = OUT_W'(SLOTS);
  localparam logic [FC_W-1:0]   FC_FULL   = FC_W'(SLOTS);

  // sequencer state
  tsa_pkg::seq_state_t state_r, state_nxt;
  tsa_pkg::cmd_t       cmd_r, cmd_nxt;
  logic [tsa_pkg::ID_W-1:0] tid_r, tid_nxt;
  logic [tsa_pkg::ID_W-1:0] key_r, key_nxt;   // value the comparator looks for
  logic [SLOT_W-1:0]   ptr_r, ptr_nxt;         // read address, also the clear pointer
  logic [SLOT_W-1:0]   cnt_r, cnt_nxt;         // reads issued so far in this scan
  logic                single_r, single_nxt;   // one-slot check (free, reclaim)
  logic                issue_done_r, issue_done_nxt;
  // compare stage, in the cycle after the read address is issued
  logic                chk_vld_r, chk_vld_nxt;
  logic [SLOT_W-1:0]   chk_ptr_r, chk_ptr_nxt;
  logic                chk_last_r, chk_last_nxt;
  // architectural state besides the table
  logic [SLOT_W-1:0]   scan_start_r, scan_start_nxt;
  logic [FC_W-1:0]     free_cnt_r, free_cnt_nxt;
  // finished result and output register
  tsa_pkg::status_t    res_status_r, res_status_nxt;
  logic [OUT_W-1:0]    res_slot_r, res_slot_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [2:0]          out_status_r, out_status_nxt;
  logic [OUT_W-1:0]    out_slot_r, out_slot_nxt;

  // table port
  logic                     ram_we;
  logic [SLOT_W-1:0]        ram_waddr;
  logic [tsa_pkg::ID_W-1:0] ram_wdata;
  logic [tsa_pkg::ID_W-1:0] ram_rdata;
  logic                     hit;
  logic                     in_range;

  tsa_ram #(
    .WIDTH (tsa_pkg::ID_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  // the shared comparator
  assign hit      = (ram_rdata == key_r);
  assign in_range = ({1'b0, in_slot} < SLOTS_X);

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tsa_pkg::SEQ_CLEAR;
      ptr_r        <= '0;
      cnt_r        <= '0;
      issue_done_r <= 1'b1;
      chk_vld_r    <= 1'b0;
      scan_start_r <= '0;
      free_cnt_r   <= FC_FULL;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ptr_r        <= ptr_nxt;
      cnt_r        <= cnt_nxt;
      issue_done_r <= issue_done_nxt;
      chk_vld_r    <= chk_vld_nxt;
      scan_start_r <= scan_start_nxt;
      free_cnt_r   <= free_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    tid_r        <= tid_nxt;
    key_r        <= key_nxt;
    single_r     <= single_nxt;
    chk_ptr_r    <= chk_ptr_nxt;
    chk_last_r   <= chk_last_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    tid_nxt        = tid_r;
    key_nxt        = key_r;
    ptr_nxt        = ptr_r;
    cnt_nxt        = cnt_r;
    single_nxt     = single_r;
    issue_done_nxt = issue_done_r;
    chk_vld_nxt    = 1'b0;
    chk_ptr_nxt    = chk_ptr_r;
    chk_last_nxt   = chk_last_r;
    scan_start_nxt = scan_start_r;
    free_cnt_nxt   = free_cnt_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    ram_we         = 1'b0;
    ram_waddr      = chk_ptr_r;
    ram_wdata      = tsa_pkg::EMPTY_MARK;
    in_ready       = 1'b0;

    // downstream takes the waiting word
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      tsa_pkg::SEQ_CLEAR: begin
        // sweep every slot to empty
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        if (ptr_r == LAST_SLOT) begin
          ptr_nxt   = '0;
          state_nxt = tsa_pkg::SEQ_IDLE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end

      tsa_pkg::SEQ_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt        = tsa_pkg::cmd_t'(in_command);
          tid_nxt        = in_thread_id;
          cnt_nxt        = '0;
          issue_done_nxt = 1'b0;
          state_nxt      = tsa_pkg::SEQ_SCAN;
          case (tsa_pkg::cmd_t'(in_command))
            tsa_pkg::CMD_ALLOC: begin
              if (free_cnt_r == '0) begin
                res_status_nxt = tsa_pkg::STS_NO_FREE;
                res_slot_nxt   = SLOT_NONE;
                issue_done_nxt = 1'b1;
                state_nxt      = tsa_pkg::SEQ_FIN;
              end
              ptr_nxt    = scan_start_r;
              key_nxt    = tsa_pkg::EMPTY_MARK;
              single_nxt = 1'b0;
            end
            tsa_pkg::CMD_FREE: begin
              if (!in_range) begin
                res_status_nxt = tsa_pkg::STS_MISMATCH;
                res_slot_nxt   = SLOT_NONE;
                issue_done_nxt = 1'b1;
                state_nxt      = tsa_pkg::SEQ_FIN;
              end
              ptr_nxt    = in_slot;
              key_nxt    = in_thread_id;
              single_nxt = 1'b1;
            end
            tsa_pkg::CMD_LOOKUP: begin
              // lowest matching slot first
              ptr_nxt    = '0;
              key_nxt    = in_thread_id;
              single_nxt = 1'b0;
            end
            tsa_pkg::CMD_RECLAIM: begin
              if (!in_range) begin
                res_status_nxt = tsa_pkg::STS_NOT_FOUND;
                res_slot_nxt   = SLOT_NONE;
                issue_done_nxt = 1'b1;
                state_nxt      = tsa_pkg::SEQ_FIN;
              end
              ptr_nxt    = in_slot;
              key_nxt    = tsa_pkg::PENDING_MARK;
              single_nxt = 1'b1;
            end
            default: begin
              state_nxt = tsa_pkg::SEQ_IDLE;
            end
          endcase
        end
      end

      tsa_pkg::SEQ_SCAN: begin
        // read issue, one slot a cycle, ends on a full wrap, a one-slot check or a hit
        if (!issue_done_r) begin
          chk_vld_nxt  = 1'b1;
          chk_ptr_nxt  = ptr_r;
          chk_last_nxt = single_r || (cnt_r == LAST_SLOT);
          ptr_nxt      = next_slot(ptr_r);
          if (single_r || (cnt_r == LAST_SLOT)) begin
            issue_done_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        // compare stage: read data belongs to chk_ptr_r
        if (chk_vld_r) begin
          if (hit) begin
            issue_done_nxt = 1'b1;
            chk_vld_nxt    = 1'b0;
            state_nxt      = tsa_pkg::SEQ_FIN;
            res_status_nxt = tsa_pkg::STS_OK;
            res_slot_nxt   = OUT_W'(chk_ptr_r);
            case (cmd_r)
              tsa_pkg::CMD_ALLOC: begin
                ram_we         = 1'b1;
                ram_wdata      = tid_r;
                free_cnt_nxt   = free_cnt_r - 1'b1;
                scan_start_nxt = next_slot(chk_ptr_r);
              end
              tsa_pkg::CMD_FREE: begin
                ram_we    = 1'b1;
                ram_wdata = tsa_pkg::PENDING_MARK;
                if (free_cnt_r < FC_FULL) begin
                  free_cnt_nxt = free_cnt_r + 1'b1;
                end
              end
              tsa_pkg::CMD_RECLAIM: begin
                // free already counted this slot
                ram_we    = 1'b1;
                ram_wdata = tsa_pkg::EMPTY_MARK;
              end
              default: begin
                ram_we = 1'b0;
              end
            endcase
          end else if (chk_last_r) begin
            issue_done_nxt = 1'b1;
            chk_vld_nxt    = 1'b0;
            state_nxt      = tsa_pkg::SEQ_FIN;
            res_slot_nxt   = SLOT_NONE;
            case (cmd_r)
              tsa_pkg::CMD_ALLOC:  res_status_nxt = tsa_pkg::STS_FULL;
              tsa_pkg::CMD_FREE:   res_status_nxt = tsa_pkg::STS_MISMATCH;
              default:             res_status_nxt = tsa_pkg::STS_NOT_FOUND;
            endcase
          end
        end
      end

      tsa_pkg::SEQ_FIN: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          state_nxt      = tsa_pkg::SEQ_IDLE;
        end
      end

      default: begin
        state_nxt = tsa_pkg::SEQ_IDLE;
      end
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_slot_out = out_slot_r;

endmodule
